[rtl/cpot_pkg.sv]
// Package for the collider pair overlap test.
// Holds the action codes and their type; depends on nothing.
package cpot_pkg;

	typedef logic [1:0] action_t;

	localparam action_t ACT_BOX_BOX       = 2'd0;
	localparam action_t ACT_CIRCLE_CIRCLE = 2'd1;
	localparam action_t ACT_BOX_CIRCLE    = 2'd2;
	localparam action_t ACT_NONE          = 2'd3;

endpackage

[rtl/collider_pair_overlap_test.sv]
// Flow: a beat accepted into stage 1 moves through stage 2 to the result register.
// Throughput: one beat per cycle while the result is not stalled; a stalled result holds only the stages behind it.
// Stages: each beat passes through three register stages. The longest of them holds
// one squarer level, or a wide sum and compare.
// Reset: arst_n clears the stage valid bits only; payload registers are not reset.
// Uses cpot_pkg for the action codes.
module collider_pair_overlap_test #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  cpot_pkg::action_t             action,
	input  logic signed [COORD_WIDTH-1:0] src_a,
	input  logic signed [COORD_WIDTH-1:0] src_b,
	input  logic signed [COORD_WIDTH-1:0] src_c,
	input  logic signed [COORD_WIDTH-1:0] src_d,
	input  logic signed [COORD_WIDTH-1:0] dst_a,
	input  logic signed [COORD_WIDTH-1:0] dst_b,
	input  logic signed [COORD_WIDTH-1:0] dst_c,
	input  logic signed [COORD_WIDTH-1:0] dst_d,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] hit_x,
	output logic signed [COORD_WIDTH-1:0] hit_y
);
	import cpot_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int M  = W + 1;     // magnitude of a difference
	localparam int SQ = 2 * M;     // square of a magnitude
	localparam int SS = SQ + 1;    // sum of two squares

	// ---------------------------------------------------------------
	// Stage enables: a stage advances when it is empty or the stage
	// ahead of it advances. The result register is the last stage.
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3 = !v_s3 || !rsp_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= req_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: compares, differences and hit point bounds.
	// Everything is widened by one bit so that sums never wrap.
	// ---------------------------------------------------------------
	logic signed [W:0] sa_e, sb_e, sc_e, sd_e, da_e, db_e, dc_e, dd_e;
	logic signed [W:0] cx_lo, cx_hi, cy_lo, cy_hi;
	logic signed [W:0] xd0, xd1, yd0, yd1, rr;
	logic signed [W:0] px_lo, px_hi, py_lo, py_hi;
	logic              bb_hit, band, band_hit;

	assign sa_e = {src_a[W-1], src_a};
	assign sb_e = {src_b[W-1], src_b};
	assign sc_e = {src_c[W-1], src_c};
	assign sd_e = {src_d[W-1], src_d};
	assign da_e = {dst_a[W-1], dst_a};
	assign db_e = {dst_b[W-1], dst_b};
	assign dc_e = {dst_c[W-1], dst_c};
	assign dd_e = {dst_d[W-1], dst_d};

	// circle's bounding box in box-circle
	assign cx_lo = da_e - dc_e;
	assign cx_hi = da_e + dc_e;
	assign cy_lo = db_e - dc_e;
	assign cy_hi = db_e + dc_e;

	// x/y differences from the destination centre; the first pair also
	// serves circle-circle
	assign xd0 = sa_e - da_e;
	assign xd1 = sc_e - da_e;
	assign yd0 = sb_e - db_e;
	assign yd1 = sd_e - db_e;

	assign bb_hit = !(src_a > dst_c || src_b > dst_d || src_c < dst_a || src_d < dst_b);

	// band case: centre within the box's x span or y span
	assign band = (src_a <= dst_a && dst_a <= src_c) || (src_b <= dst_b && dst_b <= src_d);
	assign band_hit = !((sa_e - dc_e) > da_e || (sb_e - dc_e) > db_e ||
	                    (sc_e + dc_e) < da_e || (sd_e + dc_e) < db_e);

	always_comb begin
		rr    = dc_e;
		px_lo = sa_e;
		px_hi = da_e;
		py_lo = sb_e;
		py_hi = db_e;
		case (action)
			ACT_BOX_BOX: begin
				px_lo = (sa_e > da_e) ? sa_e : da_e;
				px_hi = (sc_e < dc_e) ? sc_e : dc_e;
				py_lo = (sb_e > db_e) ? sb_e : db_e;
				py_hi = (sd_e < dd_e) ? sd_e : dd_e;
			end
			ACT_CIRCLE_CIRCLE: begin
				rr = sc_e + dc_e;
			end
			ACT_BOX_CIRCLE: begin
				px_lo = (sa_e > cx_lo) ? sa_e : cx_lo;
				px_hi = (sc_e < cx_hi) ? sc_e : cx_hi;
				py_lo = (sb_e > cy_lo) ? sb_e : cy_lo;
				py_hi = (sd_e < cy_hi) ? sd_e : cy_hi;
			end
			default: begin
				rr = dc_e;
			end
		endcase
	end

	action_t           act_s1;
	logic              bb_hit_s1, band_s1, band_hit_s1;
	logic signed [W:0] xd0_s1, xd1_s1, yd0_s1, yd1_s1, rr_s1;
	logic signed [W:0] px_lo_s1, px_hi_s1, py_lo_s1, py_hi_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			act_s1      <= action;
			bb_hit_s1   <= bb_hit;
			band_s1     <= band;
			band_hit_s1 <= band_hit;
			xd0_s1      <= xd0;
			xd1_s1      <= xd1;
			yd0_s1      <= yd0;
			yd1_s1      <= yd1;
			rr_s1       <= rr;
			px_lo_s1    <= px_lo;
			px_hi_s1    <= px_hi;
			py_lo_s1    <= py_lo;
			py_hi_s1    <= py_hi;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: squares of the magnitudes, floored half-sums.
	// ---------------------------------------------------------------
	logic [M-1:0]      m_x0, m_x1, m_y0, m_y1, m_r;
	logic [SQ-1:0]     sq_x0, sq_x1, sq_y0, sq_y1, sq_r;
	logic signed [W+1:0] sum_x, sum_y;

	assign m_x0 = xd0_s1[W] ? M'(-xd0_s1) : M'(xd0_s1);
	assign m_x1 = xd1_s1[W] ? M'(-xd1_s1) : M'(xd1_s1);
	assign m_y0 = yd0_s1[W] ? M'(-yd0_s1) : M'(yd0_s1);
	assign m_y1 = yd1_s1[W] ? M'(-yd1_s1) : M'(yd1_s1);
	assign m_r  = rr_s1[W]  ? M'(-rr_s1)  : M'(rr_s1);

	assign sq_x0 = {{M{1'b0}}, m_x0} * {{M{1'b0}}, m_x0};
	assign sq_x1 = {{M{1'b0}}, m_x1} * {{M{1'b0}}, m_x1};
	assign sq_y0 = {{M{1'b0}}, m_y0} * {{M{1'b0}}, m_y0};
	assign sq_y1 = {{M{1'b0}}, m_y1} * {{M{1'b0}}, m_y1};
	assign sq_r  = {{M{1'b0}}, m_r}  * {{M{1'b0}}, m_r};

	assign sum_x = {px_lo_s1[W], px_lo_s1} + {px_hi_s1[W], px_hi_s1};
	assign sum_y = {py_lo_s1[W], py_lo_s1} + {py_hi_s1[W], py_hi_s1};

	action_t           act_s2;
	logic              bb_hit_s2, band_s2, band_hit_s2, rneg_s2;
	logic [SQ-1:0]     sq_x0_s2, sq_x1_s2, sq_y0_s2, sq_y1_s2, sq_r_s2;
	logic signed [W:0] hx_s2, hy_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			act_s2      <= act_s1;
			bb_hit_s2   <= bb_hit_s1;
			band_s2     <= band_s1;
			band_hit_s2 <= band_hit_s1;
			rneg_s2     <= rr_s1[W];
			sq_x0_s2    <= sq_x0;
			sq_x1_s2    <= sq_x1;
			sq_y0_s2    <= sq_y0;
			sq_y1_s2    <= sq_y1;
			sq_r_s2     <= sq_r;
			// arithmetic shift floors toward minus infinity
			hx_s2       <= sum_x[W+1:1];
			hy_s2       <= sum_y[W+1:1];
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: distance compares, hit select, saturate, result register.
	// ---------------------------------------------------------------
	logic [SS-1:0]     d00, d10, d01, d11, r2;
	logic              in00, in10, in01, in11;
	logic              hit_c;
	logic              keep_pt;
	logic signed [W-1:0] sat_x, sat_y;

	assign d00 = {1'b0, sq_x0_s2} + {1'b0, sq_y0_s2};
	assign d10 = {1'b0, sq_x1_s2} + {1'b0, sq_y0_s2};
	assign d01 = {1'b0, sq_x0_s2} + {1'b0, sq_y1_s2};
	assign d11 = {1'b0, sq_x1_s2} + {1'b0, sq_y1_s2};
	assign r2  = {1'b0, sq_r_s2};

	// a negative radius never reaches a corner or another circle
	assign in00 = !rneg_s2 && (d00 <= r2);
	assign in10 = !rneg_s2 && (d10 <= r2);
	assign in01 = !rneg_s2 && (d01 <= r2);
	assign in11 = !rneg_s2 && (d11 <= r2);

	always_comb begin
		hit_c   = 1'b0;
		keep_pt = 1'b0;
		case (act_s2)
			ACT_BOX_BOX: begin
				hit_c   = bb_hit_s2;
				keep_pt = bb_hit_s2;
			end
			ACT_CIRCLE_CIRCLE: begin
				hit_c   = in00;
				keep_pt = 1'b1;
			end
			ACT_BOX_CIRCLE: begin
				hit_c   = band_s2 ? band_hit_s2 : (in00 || in10 || in01 || in11);
				keep_pt = hit_c;
			end
			default: begin
				hit_c   = 1'b0;
				keep_pt = 1'b0;
			end
		endcase
	end

	// clamp to the signed coordinate range when the top two bits differ
	assign sat_x = (hx_s2[W] != hx_s2[W-1]) ? {hx_s2[W], {(W-1){~hx_s2[W]}}} : hx_s2[W-1:0];
	assign sat_y = (hy_s2[W] != hy_s2[W-1]) ? {hy_s2[W], {(W-1){~hy_s2[W]}}} : hy_s2[W-1:0];

	logic                hit_s3;
	logic signed [W-1:0] hit_x_s3, hit_y_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			hit_s3   <= hit_c;
			hit_x_s3 <= keep_pt ? sat_x : '0;
			hit_y_s3 <= keep_pt ? sat_y : '0;
		end
	end

	assign rsp_valid = v_s3;
	assign hit       = hit_s3;
	assign hit_x     = hit_x_s3;
	assign hit_y     = hit_y_s3;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> v_s1)
		else $error("accepted beat did not land in stage 1");

	a_full_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && rsp_stall) |-> req_stall)
		else $error("full pipeline took a beat while the result stalled");

	a_no_action_miss : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en3 && act_s2 == ACT_NONE) |=> (!hit && hit_x == '0 && hit_y == '0))
		else $error("unused action produced a hit or a point");

	a_box_miss_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en3 && act_s2 == ACT_BOX_BOX && !bb_hit_s2) |=>
		(!hit && hit_x == '0 && hit_y == '0))
		else $error("box-box miss reported a nonzero point");

endmodule

[tb/collider_pair_overlap_test_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for collider_pair_overlap_test: box-box, circle-circle, box-circle
// and unused-action beats go in, each result is checked against a built-in overlap predictor.
// Depends on cpot_pkg and the collider_pair_overlap_test RTL only.
module collider_pair_overlap_test_tb;
	import cpot_pkg::*;

	localparam int      CW           = 16;
	localparam longint  COORD_MAX    = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint  COORD_MIN    = -COORD_MAX - 1;
	localparam int      RANDOM_PAIRS = 1050;
	localparam int      DRAIN_CYCLES = 12;
	localparam longint  CYCLE_LIMIT  = 100000;

	typedef logic signed [CW-1:0] coord_t;

	// One collider: box left/top/right/bottom, or circle x/y/radius/unused.
	typedef struct packed {
		coord_t a;
		coord_t b;
		coord_t c;
		coord_t d;
	} shape_t;

	typedef struct packed {
		action_t action;
		shape_t  src;
		shape_t  dst;
	} pair_t;

	typedef struct packed {
		logic          hit;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
	} overlap_t;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_stall;
	action_t action    = ACT_BOX_BOX;
	coord_t  src_a     = '0;
	coord_t  src_b     = '0;
	coord_t  src_c     = '0;
	coord_t  src_d     = '0;
	coord_t  dst_a     = '0;
	coord_t  dst_b     = '0;
	coord_t  dst_c     = '0;
	coord_t  dst_d     = '0;
	logic    rsp_valid;
	logic    rsp_stall = 1'b0;
	logic    hit;
	coord_t  hit_x;
	coord_t  hit_y;

	pair_t    pair_q[$];     // pairs waiting to be driven
	overlap_t overlap_q[$];  // predicted results, oldest first

	int     total_pairs  = 0;
	int     directed_end = 0;
	int     sent         = 0;  // pairs popped by the driver
	int     beats_taken  = 0;  // request beats accepted
	int     rsp_count    = 0;  // result beats accepted
	int     phase        = 0;  // idle profile: 0, 1 or 2
	int     mismatches   = 0;
	longint cycle_count  = 0;

	collider_pair_overlap_test #(
		.COORD_WIDTH(CW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action   (action),
		.src_a    (src_a),
		.src_b    (src_b),
		.src_c    (src_c),
		.src_d    (src_d),
		.dst_a    (dst_a),
		.dst_b    (dst_b),
		.dst_c    (dst_c),
		.dst_d    (dst_d),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.hit      (hit),
		.hit_x    (hit_x),
		.hit_y    (hit_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint floor_half(longint p, longint q);
		// arithmetic shift rounds toward minus infinity
		return (p + q) >>> 1;
	endfunction

	function automatic logic [CW-1:0] clamp_coord(longint v);
		longint c;
		c = (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
		return c[CW-1:0];
	endfunction

	function automatic longint lmax(longint p, longint q);
		return (p > q) ? p : q;
	endfunction

	function automatic longint lmin(longint p, longint q);
		return (p < q) ? p : q;
	endfunction

	// Squared distance against squared radius; a negative radius never reaches.
	// Operands stay below 2^18, so the squares fit easily in 64 bits.
	function automatic logic in_reach(longint px, longint py, longint qx, longint qy,
	                                  longint r);
		longint dx, dy;
		if (r < 0)
			return 1'b0;
		dx = px - qx;
		dy = py - qy;
		return (dx * dx + dy * dy) <= r * r;
	endfunction

	function automatic overlap_t predict_overlap(pair_t p);
		overlap_t o;
		longint   sa, sb, sc, sd, cx, cy, r, dc, dd;
		sa = $signed(p.src.a);
		sb = $signed(p.src.b);
		sc = $signed(p.src.c);
		sd = $signed(p.src.d);
		cx = $signed(p.dst.a);
		cy = $signed(p.dst.b);
		dc = $signed(p.dst.c);
		dd = $signed(p.dst.d);
		r  = dc;
		o  = '0;
		case (p.action)
			ACT_BOX_BOX: begin
				if (!(sa > dc || sb > dd || sc < cx || sd < cy)) begin
					o.hit = 1'b1;
					o.x   = clamp_coord(floor_half(lmax(sa, cx), lmin(sc, dc)));
					o.y   = clamp_coord(floor_half(lmax(sb, cy), lmin(sd, dd)));
				end
			end
			ACT_CIRCLE_CIRCLE: begin
				// midpoint of the centers is reported hit or miss
				o.hit = in_reach(sa, sb, cx, cy, sc + dc);
				o.x   = clamp_coord(floor_half(sa, cx));
				o.y   = clamp_coord(floor_half(sb, cy));
			end
			ACT_BOX_CIRCLE: begin
				if ((sa <= cx && cx <= sc) || (sb <= cy && cy <= sd))
					// center in a band: test against the box grown by r
					o.hit = !(sa - r > cx || sb - r > cy || sc + r < cx || sd + r < cy);
				else
					o.hit = in_reach(sa, sb, cx, cy, r) || in_reach(sc, sb, cx, cy, r) ||
					        in_reach(sa, sd, cx, cy, r) || in_reach(sc, sd, cx, cy, r);
				if (o.hit) begin
					o.x = clamp_coord(floor_half(lmax(sa, cx - r), lmin(sc, cx + r)));
					o.y = clamp_coord(floor_half(lmax(sb, cy - r), lmin(sd, cy + r)));
				end
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------- stimulus

	task automatic add_pair(action_t act, int sa, int sb, int sc, int sd,
	                        int da, int db, int dc, int dd);
		pair_t p;
		p.action = act;
		p.src    = {coord_t'(sa), coord_t'(sb), coord_t'(sc), coord_t'(sd)};
		p.dst    = {coord_t'(da), coord_t'(db), coord_t'(dc), coord_t'(dd)};
		pair_q.push_back(p);
	endtask

	// Shape placed around a shared base point so that pairs overlap often.
	// A few spans go negative: inverted boxes and negative radii.
	function automatic shape_t random_shape(bit circle, int bx, int by, int spread);
		shape_t s;
		int     span_x, span_y;
		s.a    = coord_t'(bx + int'($urandom_range(2 * spread)) - spread);
		s.b    = coord_t'(by + int'($urandom_range(2 * spread)) - spread);
		span_x = int'($urandom_range(spread));
		span_y = int'($urandom_range(spread));
		if ($urandom_range(99) < 6)
			span_x = -span_x;
		if ($urandom_range(99) < 6)
			span_y = -span_y;
		if (circle) begin
			s.c = ($urandom_range(99) < 5) ? coord_t'($urandom()) : coord_t'(span_x);
			s.d = coord_t'($urandom());
		end else begin
			s.c = coord_t'(s.a + span_x);
			s.d = coord_t'(s.b + span_y);
		end
		return s;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int    bx, by, spread;
		p.action = ($urandom_range(99) < 4) ? ACT_NONE : action_t'($urandom_range(2));
		if ($urandom_range(99) < 12) begin
			// raw noise: every bit of every field
			p.src = shape_t'({$urandom(), $urandom()});
			p.dst = shape_t'({$urandom(), $urandom()});
			return p;
		end
		spread = ($urandom_range(3) == 0) ? 4000 : 300;
		bx     = int'($urandom_range(65535)) - 32768;
		by     = int'($urandom_range(65535)) - 32768;
		p.src  = random_shape(p.action == ACT_CIRCLE_CIRCLE, bx, by, spread);
		p.dst  = random_shape(p.action != ACT_BOX_BOX, bx, by, spread);
		return p;
	endfunction

	// ---------------------------------------------------------------- driver

	// Present a new beat only once the previous one is taken; hold it while
	// stalled. At the end of the directed part and halfway through all the pairs,
	// hold off until every result of the beats sent so far is back.
	always @(posedge clk or negedge arst_n) begin : driver
		pair_t nxt;
		int    taken, idle_pct;
		logic  hold;
		if (!arst_n) begin
			req_valid   <= 1'b0;
			beats_taken <= 0;
		end else begin
			taken       = beats_taken + ((req_valid && !req_stall) ? 1 : 0);
			beats_taken <= taken;
			idle_pct    = (phase == 0) ? 19 : (phase == 1) ? 46 : 0;
			hold        = (sent == directed_end || sent == total_pairs / 2) &&
			              taken != rsp_count;
			if (!req_valid || !req_stall) begin
				if (pair_q.size() != 0 && !hold && $urandom_range(99) >= idle_pct) begin
					nxt       = pair_q.pop_front();
					action    <= nxt.action;
					src_a     <= nxt.src.a;
					src_b     <= nxt.src.b;
					src_c     <= nxt.src.c;
					src_d     <= nxt.src.d;
					dst_a     <= nxt.dst.a;
					dst_b     <= nxt.dst.b;
					dst_c     <= nxt.dst.c;
					dst_d     <= nxt.dst.d;
					req_valid <= 1'b1;
					sent      <= sent + 1;
					phase     <= (3 * sent < total_pairs) ? 0 :
					             (3 * sent < 2 * total_pairs) ? 1 : 2;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// Predict on every accepted request beat, then check every accepted result
	// beat against the oldest prediction. Both in one block keeps the push
	// ahead of the pop within an edge.
	always @(posedge clk or negedge arst_n) begin : monitor
		overlap_t want;
		int       stall_pct;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rsp_count <= 0;
		end else begin
			if (req_valid && !req_stall)
				overlap_q.push_back(predict_overlap({action, src_a, src_b, src_c, src_d,
				                                     dst_a, dst_b, dst_c, dst_d}));
			if (rsp_valid && !rsp_stall) begin
				rsp_count <= rsp_count + 1;
				if (overlap_q.size() == 0) begin
					mismatches++;
					$display("%0t: result %0d with no pair pending: hit %0b x %0d y %0d",
					         $time, rsp_count, hit, hit_x, hit_y);
				end else begin
					want = overlap_q.pop_front();
					if (hit !== want.hit) begin
						mismatches++;
						$display("%0t: result %0d hit expected %0b actual %0b",
						         $time, rsp_count, want.hit, hit);
					end
					if (hit_x !== want.x) begin
						mismatches++;
						$display("%0t: result %0d hit_x expected %0d actual %0d",
						         $time, rsp_count, $signed(want.x), hit_x);
					end
					if (hit_y !== want.y) begin
						mismatches++;
						$display("%0t: result %0d hit_y expected %0d actual %0d",
						         $time, rsp_count, $signed(want.y), hit_y);
					end
				end
			end
			// receiver idles in the opposite profile to the sender
			stall_pct = (phase == 0) ? 46 : (phase == 1) ? 19 : 0;
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d of %0d results back",
			         $time, cycle_count, rsp_count, total_pairs);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : sequencer
		int i;

		// box-box: overlap, touching corner, each of the four miss sides
		add_pair(ACT_BOX_BOX, 0, 0, 100, 100, 50, 50, 150, 150);
		add_pair(ACT_BOX_BOX, 0, 0, 100, 100, 100, 100, 200, 200);
		add_pair(ACT_BOX_BOX, 200, 0, 300, 100, 0, 0, 100, 100);
		add_pair(ACT_BOX_BOX, 0, 200, 100, 300, 0, 0, 100, 100);
		add_pair(ACT_BOX_BOX, 0, 0, 100, 100, 101, 0, 200, 100);
		add_pair(ACT_BOX_BOX, 0, 0, 100, 100, 0, 101, 100, 200);
		// full-range boxes, inverted source box, odd negative half-sum
		add_pair(ACT_BOX_BOX, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
		add_pair(ACT_BOX_BOX, 100, 100, -100, -100, -200, -200, 200, 200);
		add_pair(ACT_BOX_BOX, -3, -3, 0, 0, -3, -3, 0, 0);
		// circle-circle: tangent, just apart, negative radius sum, coincident,
		// extreme centers that miss and that hit with the largest radii
		add_pair(ACT_CIRCLE_CIRCLE, 0, 0, 50, 0, 60, 80, 50, 0);
		add_pair(ACT_CIRCLE_CIRCLE, 0, 0, 49, 0, 60, 80, 50, 0);
		add_pair(ACT_CIRCLE_CIRCLE, 0, 0, -1, 0, 0, 0, 0, 0);
		add_pair(ACT_CIRCLE_CIRCLE, 5, 5, 0, -1, 5, 5, 0, -32768);
		add_pair(ACT_CIRCLE_CIRCLE, -32768, -32768, 32767, 0, 32767, 32767, 32767, 0);
		add_pair(ACT_CIRCLE_CIRCLE, -32768, -32768, 32767, 32767, 32000, -32768, 32767, -1);
		// box-circle: band hits and misses on both axes, corner exact hit and
		// miss, negative radius in a band and at a corner
		add_pair(ACT_BOX_CIRCLE, 0, 0, 100, 100, 50, 150, 50, 0);
		add_pair(ACT_BOX_CIRCLE, 0, 0, 100, 100, 50, 151, 50, 0);
		add_pair(ACT_BOX_CIRCLE, 0, 0, 100, 100, -50, 50, 50, 0);
		add_pair(ACT_BOX_CIRCLE, 0, 0, 100, 100, -60, 50, 50, 0);
		add_pair(ACT_BOX_CIRCLE, 0, 0, 100, 100, 130, 140, 50, 0);
		add_pair(ACT_BOX_CIRCLE, 0, 0, 100, 100, 131, 140, 50, 0);
		add_pair(ACT_BOX_CIRCLE, 0, 0, 100, 100, -30, -40, 50, 0);
		add_pair(ACT_BOX_CIRCLE, 0, 0, 100, 100, 130, 140, -5, 0);
		add_pair(ACT_BOX_CIRCLE, -32768, -32768, 32767, 32767, 0, 0, -32767, 0);
		add_pair(ACT_BOX_CIRCLE, 0, 0, 100, 100, 50, 50, -60, 0);
		add_pair(ACT_BOX_CIRCLE, 100, -32768, -100, 32767, 0, 0, 32767, 32767);
		// unused action reports nothing
		add_pair(ACT_NONE, 1, 2, 3, 4, 5, 6, 7, 8);
		directed_end = pair_q.size();

		for (i = 0; i < RANDOM_PAIRS; i++)
			pair_q.push_back(random_pair());
		total_pairs = pair_q.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last result, then give stray beats a chance to show
		while (rsp_count < total_pairs)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (overlap_q.size() != 0) begin
			mismatches += overlap_q.size();
			$display("%0t: %0d predicted results never arrived", $time, overlap_q.size());
		end
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
